// ----- design/swhp_pkg.sv -----
// Package for the spatial whitening Hermitian product block.
// Holds sizes, payload structs, the pair table and state encodings; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swhp_pkg;

   localparam int CHAN_COUNT   = 4;
   localparam int PAIR_SLOTS   = 6;
   localparam int ITEM_COUNT   = PAIR_SLOTS + CHAN_COUNT;
   localparam int MAT_SIZE     = CHAN_COUNT * CHAN_COUNT;
   localparam int REAL_PAIRS   = CHAN_COUNT * (CHAN_COUNT - 1) / 2;
   localparam int CH_W         = $clog2(CHAN_COUNT);
   localparam int POS_W        = $clog2(ITEM_COUNT + 1);
   localparam int ADDR_W       = $clog2(MAT_SIZE);
   localparam int IDX_W        = $clog2(ITEM_COUNT);
   localparam int ACC_W        = 64;
   localparam int QUEUE_DEPTH  = 2;

   typedef struct packed {
      logic signed [31:0] target_re;
      logic signed [31:0] target_im;
      logic signed [31:0] interf_re;
      logic signed [31:0] interf_im;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_re;
      logic signed [31:0] out_im;
      logic               is_diagonal;
      logic               out_last;
   } rsp_type;

   // One queued request between the loader and the compute engine.
   typedef struct packed {
      logic [POS_W-1:0]   pos;
      req_type            data;
   } cmd_type;

   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] ci;
      logic [CH_W-1:0] cj;
   } pair_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE2,
      ST_MAC,
      ST_OUT_A,
      ST_OUT_B,
      ST_OUT_C,
      ST_EMIT
   } eng_state_type;

   function automatic pair_type pair_lookup(input logic [POS_W-1:0] p);
      pair_type r;
      int k;
      r = '0;
      k = 0;
      for (int i = 0; i < CHAN_COUNT; i++) begin
         for (int j = i + 1; j < CHAN_COUNT; j++) begin
            if (k == int'(p)) begin
               r.valid = 1'b1;
               r.ci    = CH_W'(i);
               r.cj    = CH_W'(j);
            end
            k++;
         end
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

// ----- design/swhp_loader.sv -----
// Front end: tracks the packed load position and queues tagged requests.
// Depends on swhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swhp_loader import swhp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  wire logic    cmd_take
);

   cmd_type          q_ff [QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             push_ok;
   cmd_type          entry;

   assign req_full  = (count_ff == 2'(QUEUE_DEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      entry.pos  = pos_ff;
      entry.data = req_data;
      pos_in     = pos_ff;
      if (push_ok) begin
         // A request that ends the bin restarts the position.
         if (req_data.last) begin
            pos_in = '0;
         end else if (pos_ff < POS_W'(ITEM_COUNT)) begin
            pos_in = pos_ff + 1'b1;
         end
      end
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ (cmd_take && cmd_valid);
      count_in  = count_ff + 2'(push_ok) - 2'(cmd_take && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

// ----- design/swhp_engine.sv -----
// Back end: matrix stores, shared complex MAC and result formatting.
// Depends on swhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swhp_engine import swhp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_take,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_ready
);

   // Matrix stores: one write and one registered read per cycle each.
   // Imaginary parts keep 33 bits so the conjugate of the most negative value stays exact.
   logic [64:0] nmat [MAT_SIZE];
   logic [64:0] smat [MAT_SIZE];
   logic [127:0] cmat [MAT_SIZE];

   eng_state_type    state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CH_W-1:0]  r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [1:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0] c1_re_ff, c1_im_ff;
   logic [64:0]      nrd_ff, srd_ff;
   logic [127:0]     crd_ff;
   logic signed [63:0] p_ff [4];
   logic             p_vld_ff, p_last_ff;
   logic             rd_vld_ff, rd_last_ff;
   rsp_type          out_ff, out_in;
   logic             out_vld_ff, out_vld_in;

   // Store write ports and read addresses.
   logic              wr_en, wr_en2;
   logic [ADDR_W-1:0] wr_addr;
   logic [64:0]       wr_n, wr_s;
   logic              cw_en;
   logic [ADDR_W-1:0] n_addr, s_addr, c_addr;
   logic              mac_issue, mac_last;
   pair_type          pr, opr;
   logic [POS_W-1:0]  dpos;
   logic [CH_W-1:0]   d_ch;
   logic signed [32:0] ni_ext, ti_ext;
   logic signed [32:0] n_re, n_im, s_re, s_im;

   function automatic logic signed [63:0] mulr(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [63:0] m;
      m = a * b;
      return (m + 64'sd32768) >>> 16;
   endfunction

   function automatic logic [CH_W-1:0] dpos_o(input logic [IDX_W-1:0] o);
      logic [IDX_W-1:0] t;
      t = o - IDX_W'(PAIR_SLOTS);
      return t[CH_W-1:0];
   endfunction

   assign pr     = pair_lookup(cmd_ff.pos);
   assign dpos   = cmd_ff.pos - POS_W'(PAIR_SLOTS);
   assign d_ch   = dpos[CH_W-1:0];
   assign opr    = pair_lookup(POS_W'(oidx_ff));
   assign ni_ext = {cmd_ff.data.interf_im[31], cmd_ff.data.interf_im};
   assign ti_ext = {cmd_ff.data.target_im[31], cmd_ff.data.target_im};
   assign n_re   = {nrd_ff[64], nrd_ff[64:33]};
   assign n_im   = nrd_ff[32:0];
   assign s_re   = {srd_ff[64], srd_ff[64:33]};
   assign s_im   = srd_ff[32:0];

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      phase_in  = phase_ff;
      oidx_in   = oidx_ff;
      cmd_take  = 1'b0;
      wr_en     = 1'b0;
      wr_en2    = 1'b0;
      wr_addr   = '0;
      wr_n      = '0;
      wr_s      = '0;
      mac_issue = 1'b0;
      mac_last  = 1'b0;
      n_addr    = {r_ff, k_ff};
      s_addr    = {k_ff, c_ff};
      c_addr    = '0;
      out_in    = out_ff;
      out_vld_in = out_vld_ff && !out_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data;
               state_in = ST_WRITE2;
            end
         end
         ST_WRITE2: begin
            // The first phase writes [i][j] or the diagonal, the second the conjugate.
            if (cmd_ff.pos < POS_W'(PAIR_SLOTS)) begin
               if (pr.valid) begin
                  wr_en   = (phase_ff == 2'd0);
                  wr_en2  = (phase_ff == 2'd1);
                  wr_addr = (phase_ff == 2'd0) ? {pr.ci, pr.cj} : {pr.cj, pr.ci};
                  wr_n = (phase_ff == 2'd0) ?
                     {cmd_ff.data.interf_re, ni_ext} :
                     {cmd_ff.data.interf_re, 33'(-ni_ext)};
                  wr_s = (phase_ff == 2'd0) ?
                     {cmd_ff.data.target_re, ti_ext} :
                     {cmd_ff.data.target_re, 33'(-ti_ext)};
               end
            end else if (cmd_ff.pos < POS_W'(ITEM_COUNT)) begin
               wr_en   = (phase_ff == 2'd0);
               wr_addr = {d_ch, d_ch};
               wr_n    = {cmd_ff.data.interf_re, 33'd0};
               wr_s    = {cmd_ff.data.target_re, 33'd0};
            end
            if (phase_ff == 2'd1) begin
               phase_in = 2'd0;
               r_in = '0;
               c_in = '0;
               k_in = '0;
               state_in = cmd_ff.data.last ? ST_MAC : ST_IDLE;
            end else begin
               phase_in = 2'd1;
            end
         end
         ST_MAC: begin
            mac_issue = 1'b1;
            mac_last  = (k_ff == CH_W'(CHAN_COUNT - 1));
            if (mac_last) begin
               k_in = '0;
               if (c_ff == CH_W'(CHAN_COUNT - 1)) begin
                  c_in = '0;
                  if (r_ff == CH_W'(CHAN_COUNT - 1)) begin
                     oidx_in  = '0;
                     state_in = ST_OUT_A;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_OUT_A: begin
            // Wait for the MAC pipe to drain, then read C[i][j] or C[d][d].
            if (!p_vld_ff && !rd_vld_ff) begin
               state_in = ST_OUT_B;
            end
         end
         ST_OUT_B: begin
            state_in = ST_OUT_C;
         end
         ST_OUT_C: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_vld_ff || out_ready) begin
               out_vld_in = 1'b1;
               out_in.out_last    = (oidx_ff == IDX_W'(ITEM_COUNT - 1));
               out_in.is_diagonal = 1'b0;
               out_in.out_re = '0;
               out_in.out_im = '0;
               if (oidx_ff < IDX_W'(PAIR_SLOTS)) begin
                  if (opr.valid) begin
                     out_in.out_re = sat32((c1_re_ff + $signed(crd_ff[127:64]) + 64'sd1)
                                           >>> 1);
                     out_in.out_im = sat32((c1_im_ff - $signed(crd_ff[63:0]) + 64'sd1)
                                           >>> 1);
                  end
               end else begin
                  out_in.is_diagonal = 1'b1;
                  out_in.out_re = sat32(c1_re_ff);
               end
               if (oidx_ff == IDX_W'(ITEM_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  oidx_in  = oidx_ff + 1'b1;
                  state_in = ST_OUT_A;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_OUT_A || state_ff == ST_OUT_B) begin
         if (oidx_ff < IDX_W'(PAIR_SLOTS)) begin
            c_addr = (state_ff == ST_OUT_A) ? {opr.ci, opr.cj} : {opr.cj, opr.ci};
         end else begin
            c_addr = {dpos_o(oidx_ff), dpos_o(oidx_ff)};
         end
      end
   end

   // MAC pipeline: read stage, multiply stage, accumulate stage.
   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      cw_en     = 1'b0;
      if (p_vld_ff) begin
         acc_re_in = acc_re_ff + p_ff[0] - p_ff[1];
         acc_im_in = acc_im_ff + p_ff[2] + p_ff[3];
         cw_en     = p_last_ff;
      end
   end

   logic [ADDR_W-1:0] cw_addr_ff, cw_addr_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= '0;
         out_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         p_vld_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         out_vld_ff <= out_vld_in;
         rd_vld_ff  <= mac_issue;
         p_vld_ff   <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      k_ff       <= k_in;
      oidx_ff    <= oidx_in;
      out_ff     <= out_in;
      rd_last_ff <= mac_last;
      p_last_ff  <= rd_last_ff;
      cw_addr_ff   <= {r_ff, c_ff};
      cw_addr_p_ff <= cw_addr_ff;
      if (wr_en || wr_en2) begin
         nmat[wr_addr] <= wr_n;
         smat[wr_addr] <= wr_s;
      end
      nrd_ff <= nmat[n_addr];
      srd_ff <= smat[s_addr];
      // The second read holds C[j][i] through the emit step.
      if (state_ff == ST_OUT_A || state_ff == ST_OUT_B) begin
         crd_ff <= cmat[c_addr];
      end
      p_ff[0] <= mulr(n_re, s_re);
      p_ff[1] <= mulr(n_im, s_im);
      p_ff[2] <= mulr(n_re, s_im);
      p_ff[3] <= mulr(n_im, s_re);
      if (cw_en) begin
         cmat[cw_addr_p_ff] <= {acc_re_in, acc_im_in};
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (p_vld_ff) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end else if (state_ff == ST_WRITE2) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end
      if (state_ff == ST_OUT_B) begin
         c1_re_ff <= $signed(crd_ff[127:64]);
         c1_im_ff <= $signed(crd_ff[63:0]);
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

endmodule
`default_nettype wire

// ----- design/spatial_whitening_hermitian_product_top.sv -----
// A loading request passes through idle and the write state in the engine; a closing
// request then runs a MAC step per row, column and term, drains the MAC pipe, and emits
// each result through OUT_A, OUT_B, OUT_C and EMIT. A new request is taken only in idle.
// A result left unpopped stalls the engine, and the two-entry queue then fills.
// Reset: synchronous, active high; clears the load position, queue and engine control.
// Matrix stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module spatial_whitening_hermitian_product_top import swhp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   logic    cmd_valid, cmd_take, out_valid;
   cmd_type cmd_data;

   swhp_loader u_loader (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   swhp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .out_valid (out_valid),
      .out_data  (rsp_data),
      .out_ready (rsp_pop)
   );

   assign rsp_empty = !out_valid;

`ifndef ASSERT_OFF
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("engine took from an empty queue");
   a_diag_im: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.is_diagonal) |-> (rsp_data.out_im == 32'sd0))
      else $error("diagonal result with nonzero imaginary part");
   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_last) |-> rsp_data.is_diagonal)
      else $error("final result is not a diagonal term");
`endif

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the spatial whitening Hermitian product block.
// Predicts each bin's whitened results in Q16.16 and checks every response;
// depends on swhp_pkg and spatial_whitening_hermitian_product_top.
`timescale 1ns / 1ps
module testbench;
   import swhp_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 200;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   spatial_whitening_hermitian_product_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Model copy of both matrices, kept as full complex arrays.
   longint  target_re_m [MAT_SIZE];
   longint  target_im_m [MAT_SIZE];
   longint  interf_re_m [MAT_SIZE];
   longint  interf_im_m [MAT_SIZE];
   int      load_pos;
   rsp_type whitened_q[$];

   int  mismatches;
   int  results_seen;
   int  requests_sent;
   int  bins_sent;
   int  idle_cycles;
   int  hold_cycles;
   bit  quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint mul_round(input longint a, input longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Channels of a cross term, counted in upper-triangle row order.
   task automatic pair_channels(input int p, output int ci, output int cj);
      int k;
      k = 0;
      ci = 0;
      cj = 0;
      for (int i = 0; i < CHAN_COUNT; i++) begin
         for (int j = i + 1; j < CHAN_COUNT; j++) begin
            if (k == p) begin
               ci = i;
               cj = j;
            end
            k++;
         end
      end
   endtask

   // Store one accepted request and, on a closing request, queue the bin's results.
   task automatic whiten_request(input req_type r);
      int ci, cj, d, na, sa;
      longint pre [MAT_SIZE];
      longint pim [MAT_SIZE];
      longint are, aim;
      rsp_type o;
      if (load_pos < ITEM_COUNT) begin
         if (load_pos < PAIR_SLOTS) begin
            pair_channels(load_pos, ci, cj);
            if (load_pos < REAL_PAIRS) begin
               target_re_m[ci*CHAN_COUNT+cj] = r.target_re;
               target_im_m[ci*CHAN_COUNT+cj] = r.target_im;
               target_re_m[cj*CHAN_COUNT+ci] = r.target_re;
               target_im_m[cj*CHAN_COUNT+ci] = -longint'(r.target_im);
               interf_re_m[ci*CHAN_COUNT+cj] = r.interf_re;
               interf_im_m[ci*CHAN_COUNT+cj] = r.interf_im;
               interf_re_m[cj*CHAN_COUNT+ci] = r.interf_re;
               interf_im_m[cj*CHAN_COUNT+ci] = -longint'(r.interf_im);
            end
         end else begin
            d = load_pos - PAIR_SLOTS;
            target_re_m[d*CHAN_COUNT+d] = r.target_re;
            target_im_m[d*CHAN_COUNT+d] = 0;
            interf_re_m[d*CHAN_COUNT+d] = r.interf_re;
            interf_im_m[d*CHAN_COUNT+d] = 0;
         end
         load_pos++;
      end
      if (!r.last) begin
         return;
      end
      for (int row = 0; row < CHAN_COUNT; row++) begin
         for (int col = 0; col < CHAN_COUNT; col++) begin
            are = 0;
            aim = 0;
            for (int k = 0; k < CHAN_COUNT; k++) begin
               na = row*CHAN_COUNT + k;
               sa = k*CHAN_COUNT + col;
               are += mul_round(interf_re_m[na], target_re_m[sa])
                    - mul_round(interf_im_m[na], target_im_m[sa]);
               aim += mul_round(interf_re_m[na], target_im_m[sa])
                    + mul_round(interf_im_m[na], target_re_m[sa]);
            end
            pre[row*CHAN_COUNT+col] = are;
            pim[row*CHAN_COUNT+col] = aim;
         end
      end
      for (int p = 0; p < ITEM_COUNT; p++) begin
         o = '0;
         if (p < PAIR_SLOTS) begin
            if (p < REAL_PAIRS) begin
               pair_channels(p, ci, cj);
               o.out_re = clip32((pre[ci*CHAN_COUNT+cj] + pre[cj*CHAN_COUNT+ci] + 1)
                                 >>> 1);
               o.out_im = clip32((pim[ci*CHAN_COUNT+cj] - pim[cj*CHAN_COUNT+ci] + 1)
                                 >>> 1);
            end
         end else begin
            d = p - PAIR_SLOTS;
            o.out_re = clip32(pre[d*CHAN_COUNT+d]);
            o.is_diagonal = 1'b1;
         end
         o.out_last = (p == ITEM_COUNT - 1);
         whitened_q.push_back(o);
      end
      load_pos = 0;
   endtask

   task automatic send_request(input req_type r);
      if (!quiet && $urandom_range(99) < 17) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do begin
         @(posedge clock);
      end while (req_full);
      whiten_request(r);
      requests_sent++;
   endtask

   function automatic logic [31:0] pick_value(input int style);
      case (style)
         0: return $urandom;
         1: return 32'($signed($urandom_range(262143)) - 131072);
         2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(3) == 0 ? 32'h0 :
                         32'($signed($urandom_range(8191)) - 4096);
      endcase
   endfunction

   // One bin of count requests; the closing flag rides on the last one.
   task automatic send_bin(input int count, input int style);
      req_type r;
      for (int n = 0; n < count; n++) begin
         r.target_re = pick_value(style < 0 ? $urandom_range(3) : style);
         r.target_im = pick_value(style < 0 ? $urandom_range(3) : style);
         r.interf_re = pick_value(style < 0 ? $urandom_range(3) : style);
         r.interf_im = pick_value(style < 0 ? $urandom_range(3) : style);
         r.last      = (n == count - 1);
         send_request(r);
      end
      bins_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (whitened_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_extremes();
      send_bin(ITEM_COUNT, 2);
      send_bin(ITEM_COUNT, 1);
      wait_drained();
   endtask

   task automatic test_load_order();
      // Closing early reuses entries from the previous bin; surplus requests are dropped.
      send_bin(3, 1);
      send_bin(1, 3);
      send_bin(ITEM_COUNT + 3, 0);
      wait_drained();
   endtask

   task automatic test_random_bins();
      int count;
      for (int b = 0; b < 14; b++) begin
         quiet = (b >= 6 && b < 10);
         case ($urandom_range(9))
            0: count = $urandom_range(1, ITEM_COUNT - 1);
            1: count = ITEM_COUNT + $urandom_range(1, 3);
            default: count = ITEM_COUNT;
         endcase
         send_bin(count, -1);
      end
      quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_cycles = HOLD_CYCLES;
      for (int b = 0; b < 3; b++) begin
         send_bin(ITEM_COUNT, 3);
      end
      wait_drained();
   endtask

   // Response side: random pops, with a long hold-off on request.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_pop <= quiet || ($urandom_range(99) >= 17);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (whitened_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected response re=%h im=%h diag=%b last=%b", rsp_data.out_re,
                        rsp_data.out_im, rsp_data.is_diagonal, rsp_data.out_last);
            end
         end else begin
            want = whitened_q.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected re=%h im=%h diag=%b last=%b,",
                           want.out_re, want.out_im, want.is_diagonal, want.out_last);
                  $display("          got      re=%h im=%h diag=%b last=%b",
                           rsp_data.out_re, rsp_data.out_im, rsp_data.is_diagonal,
                           rsp_data.out_last);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted request or response.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_push    = 1'b0;
      req_data    = '0;
      quiet       = 1'b0;
      hold_cycles = 0;
      idle_cycles = 0;
      mismatches  = 0;
      load_pos    = 0;
      for (int k = 0; k < MAT_SIZE; k++) begin
         target_re_m[k] = 0;
         target_im_m[k] = 0;
         interf_re_m[k] = 0;
         interf_im_m[k] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_load_order();
      test_random_bins();
      test_backpressure();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests in %0d bins, checked %0d whitened results.",
               requests_sent, bins_sent, results_seen);
      if (mismatches == 0 && whitened_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
